// ----- design/snpp_pkg.sv -----
// ----------------------------------------------------------------------------
// snpp_pkg
// Shared types and constants for the pad/mouse serial poller.
// ----------------------------------------------------------------------------
package snpp_pkg;

   // number of bytes read per poll
   localparam int POLL_BYTES = 4;
   localparam int SHIFT_W    = 32;
   localparam int POS_W      = $clog2(SHIFT_W);

   // clock pulses in one poll
   localparam logic [5:0] POLL_BITS = 6'(8 * POLL_BYTES);

   // configuration register indexes
   localparam logic CSR_LATCH_TICKS       = 1'b0;
   localparam logic CSR_HALF_PERIOD_TICKS = 1'b1;

   // configuration reset values
   localparam logic [7:0] LATCH_TICKS_RST       = 8'd12;
   localparam logic [7:0] HALF_PERIOD_TICKS_RST = 8'd6;

   // byte 1 low nibble codes
   localparam logic [3:0] NIB_NES   = 4'hf;
   localparam logic [3:0] NIB_MOUSE = 4'he;

   // pad kind codes
   localparam logic [1:0] KIND_SNES  = 2'd0;
   localparam logic [1:0] KIND_NES   = 2'd1;
   localparam logic [1:0] KIND_MOUSE = 2'd2;

   // poll sequencer phases
   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_LATCH = 4'b0010,
      PH_HIGH  = 4'b0100,
      PH_LOW   = 4'b1000
   } snpp_phase_type;

   typedef struct packed {
      logic start_poll;
      logic data_line;
      logic report_taken;
   } snpp_req_type;

   typedef struct packed {
      logic        latch_level;
      logic        clock_level;
      logic        busy_res;
      logic        report_valid;
      logic [1:0]  pad_kind;
      logic [15:0] buttons;
      logic [31:0] raw_bytes;
      logic        changed;
   } snpp_rsp_type;

   // zero duration acts as one tick
   function automatic logic [7:0] eff_dur(input logic [7:0] v);
      return (v == 8'd0) ? 8'd1 : v;
   endfunction

endpackage

// ----- design/snpp_core.sv -----
// ----------------------------------------------------------------------------
// snpp_core
// Poll sequencer: phase, tick and bit counters, shift store and the
// read/reported byte registers; forms the response word for each tick.
// ----------------------------------------------------------------------------
module snpp_core import snpp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         tick_accept,
   input  snpp_req_type tick_word,
   input  logic [7:0]   latch_ticks,
   input  logic [7:0]   half_period_ticks,
   output snpp_rsp_type result_word
);

   snpp_phase_type      phase_ff, phase_in, phase_cur;
   logic [7:0]          tick_count_ff, tick_count_in, tick_cur;
   logic [5:0]          bit_count_ff, bit_count_in, bit_cur, bit_next;
   logic [SHIFT_W-1:0]  shift_ff, shift_in, shift_cur;
   logic [31:0]         read_bytes_ff, read_bytes_in;
   logic [31:0]         reported_ff, reported_in;
   logic [8:0]          tick_inc;
   logic [7:0]          latch_dur, half_dur;
   logic [POS_W-1:0]    bit_pos;
   logic                report_valid;
   logic [3:0]          nib;

   assign latch_dur = eff_dur(latch_ticks);
   assign half_dur  = eff_dur(half_period_ticks);

   // start of poll overrides idle state for this tick
   always_comb begin
      phase_cur = phase_ff;
      tick_cur  = tick_count_ff;
      bit_cur   = bit_count_ff;
      shift_cur = shift_ff;
      if (phase_ff == PH_IDLE && tick_word.start_poll) begin
         phase_cur = PH_LATCH;
         tick_cur  = 8'd0;
         bit_cur   = 6'd0;
         shift_cur = '0;
      end
   end

   assign tick_inc = {1'b0, tick_cur} + 9'd1;
   assign bit_next = bit_cur + 6'd1;
   // msb first within each byte
   assign bit_pos  = {bit_cur[POS_W-1:3], ~bit_cur[2:0]};

   // phase sequencing
   always_comb begin
      phase_in      = phase_cur;
      tick_count_in = tick_cur;
      bit_count_in  = bit_cur;
      shift_in      = shift_cur;
      read_bytes_in = read_bytes_ff;
      report_valid  = 1'b0;
      unique case (phase_cur)
         PH_IDLE: begin
         end
         PH_LATCH: begin
            if (tick_inc >= {1'b0, latch_dur}) begin
               phase_in      = PH_HIGH;
               tick_count_in = 8'd0;
            end else begin
               tick_count_in = tick_inc[7:0];
            end
         end
         PH_HIGH: begin
            if (tick_inc >= {1'b0, half_dur}) begin
               phase_in      = PH_LOW;
               tick_count_in = 8'd0;
            end else begin
               tick_count_in = tick_inc[7:0];
            end
         end
         PH_LOW: begin
            // sample inverted data at the falling edge
            if (tick_cur == 8'd0 && !tick_word.data_line) begin
               shift_in = shift_cur | (SHIFT_W'(1) << bit_pos);
            end
            if (tick_inc >= {1'b0, half_dur}) begin
               tick_count_in = 8'd0;
               if (bit_next >= POLL_BITS) begin
                  read_bytes_in = shift_in;
                  phase_in      = PH_IDLE;
                  bit_count_in  = 6'd0;
                  report_valid  = 1'b1;
               end else begin
                  bit_count_in = bit_next;
                  phase_in     = PH_HIGH;
               end
            end else begin
               tick_count_in = tick_inc[7:0];
            end
         end
         default: begin
            phase_in      = PH_IDLE;
            tick_count_in = 8'd0;
         end
      endcase
   end

   // classification and report fields
   assign nib = read_bytes_in[11:8];

   always_comb begin
      result_word              = '0;
      result_word.latch_level  = (phase_cur == PH_LATCH);
      result_word.clock_level  = (phase_cur != PH_LOW);
      result_word.busy_res     = (phase_cur != PH_IDLE);
      result_word.report_valid = report_valid;
      result_word.raw_bytes    = read_bytes_in;
      result_word.changed      = (read_bytes_in != reported_ff);
      if (nib == NIB_NES) begin
         result_word.pad_kind = KIND_NES;
         result_word.buttons  = {8'd0, read_bytes_in[7:0]};
      end else begin
         result_word.pad_kind = (nib == NIB_MOUSE) ? KIND_MOUSE : KIND_SNES;
         result_word.buttons  = read_bytes_in[15:0];
      end
   end

   // copy taken after the compare
   assign reported_in = tick_word.report_taken ? read_bytes_in : reported_ff;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_count_ff <= 8'd0;
         bit_count_ff  <= 6'd0;
         shift_ff      <= '0;
         read_bytes_ff <= 32'd0;
         reported_ff   <= 32'd0;
      end else if (tick_accept) begin
         phase_ff      <= phase_in;
         tick_count_ff <= tick_count_in;
         bit_count_ff  <= bit_count_in;
         shift_ff      <= shift_in;
         read_bytes_ff <= read_bytes_in;
         reported_ff   <= reported_in;
      end
   end

endmodule

// ----- design/snpp_skid.sv -----
// ----------------------------------------------------------------------------
// snpp_skid
// Response output register with one skid entry; input stall comes from
// the skid entry only.
// ----------------------------------------------------------------------------
module snpp_skid import snpp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_accept,
   input  snpp_rsp_type in_word,
   output logic         in_stall,
   output logic         out_valid,
   input  logic         out_stall,
   output snpp_rsp_type out_word
);

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   snpp_rsp_type out_word_ff, out_word_in;
   snpp_rsp_type skid_word_ff, skid_word_in;
   logic         out_take;

   assign out_take  = out_valid_ff && !out_stall;
   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;

   // output and skid steering
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_word_in   = out_word_ff;
      skid_word_in  = skid_word_ff;
      if (in_accept) begin
         if (!out_valid_ff || out_take) begin
            out_valid_in = 1'b1;
            out_word_in  = in_word;
         end else begin
            skid_valid_in = 1'b1;
            skid_word_in  = in_word;
         end
      end else if (out_take) begin
         if (skid_valid_ff) begin
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

endmodule

// ----- design/snes_pad_mouse_poller_unit.sv -----
// output: a response word is registered in the output register, or in the skid
//   entry while the output register is held, when its tick word is accepted
// throughput: one tick word per cycle while the skid entry is empty, set by
//   the sequencer update and the output register with one skid entry
// reset: synchronous; sequencer idle, byte registers zero, latch 12 and
//   half period 6 ticks, output and skid empty
// ----------------------------------------------------------------------------
// snes_pad_mouse_poller_unit
// Tick-driven poller for the pad serial port: latch pulse, clock pulses,
// data sampling, pad classification and change reporting.
// ----------------------------------------------------------------------------
module snes_pad_mouse_poller_unit import snpp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  snpp_req_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output snpp_rsp_type rsp_word,
   input  logic         csr_write_en,
   input  logic         csr_index,
   input  logic [7:0]   csr_wdata
);

   logic [7:0]   latch_ticks_ff, latch_ticks_in;
   logic [7:0]   half_period_ff, half_period_in;
   logic         req_accept;
   snpp_rsp_type core_word;

   assign req_accept = req_valid && !req_stall;

   // configuration registers
   always_comb begin
      latch_ticks_in = latch_ticks_ff;
      half_period_in = half_period_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_LATCH_TICKS:       latch_ticks_in = csr_wdata;
            CSR_HALF_PERIOD_TICKS: half_period_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ticks_ff <= LATCH_TICKS_RST;
         half_period_ff <= HALF_PERIOD_TICKS_RST;
      end else begin
         latch_ticks_ff <= latch_ticks_in;
         half_period_ff <= half_period_in;
      end
   end

   // sequencer
   snpp_core u_core (
      .clock             (clock),
      .reset             (reset),
      .tick_accept       (req_accept),
      .tick_word         (req_word),
      .latch_ticks       (latch_ticks_ff),
      .half_period_ticks (half_period_ff),
      .result_word       (core_word)
   );

   // response buffering
   snpp_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .in_word   (core_word),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (rsp_word)
   );

endmodule

// ----- dv/tb_snes_pad_mouse_poller_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_snes_pad_mouse_poller_unit
// Self-checking bench for the pad/mouse serial poller. Every accepted tick
// word runs through a local copy of the poll sequencer, and each response
// word is compared field by field with the oldest predicted report. The run
// covers a directed table after reset, then random polls under several
// latch and half-period settings with random idling and back-pressure.
// ----------------------------------------------------------------------------
module tb_snes_pad_mouse_poller_unit;
   import snpp_pkg::*;

   localparam int DIR_ROWS   = 24;
   localparam int TICK_LIMIT = 600000;
   localparam int HOLD_TICKS = 300;

   // report words that can be read off directly
   localparam snpp_rsp_type IDLE_REPORT = '{latch_level: 1'b0, clock_level: 1'b1,
      busy_res: 1'b0, report_valid: 1'b0, pad_kind: KIND_SNES, buttons: 16'h0,
      raw_bytes: 32'h0, changed: 1'b0};
   localparam snpp_rsp_type LATCH_REPORT = '{latch_level: 1'b1, clock_level: 1'b1,
      busy_res: 1'b1, report_valid: 1'b0, pad_kind: KIND_SNES, buttons: 16'h0,
      raw_bytes: 32'h0, changed: 1'b0};

   typedef struct packed {
      snpp_req_type word;
      logic         typed;
      snpp_rsp_type report;
   } tick_row_type;

   // word bits are {start_poll, data_line, report_taken}; reset config 12 / 6
   localparam tick_row_type DIR_TABLE [DIR_ROWS] = '{
      '{3'b000, 1'b1, IDLE_REPORT},
      '{3'b010, 1'b1, IDLE_REPORT},
      '{3'b001, 1'b1, IDLE_REPORT},
      '{3'b011, 1'b1, IDLE_REPORT},
      '{3'b100, 1'b1, LATCH_REPORT},
      '{3'b110, 1'b1, LATCH_REPORT},
      '{3'b101, 1'b1, LATCH_REPORT},
      '{3'b111, 1'b1, LATCH_REPORT},
      '{3'b000, 1'b1, LATCH_REPORT},
      '{3'b010, 1'b1, LATCH_REPORT},
      '{3'b001, 1'b1, LATCH_REPORT},
      '{3'b100, 1'b1, LATCH_REPORT},
      '{3'b011, 1'b1, LATCH_REPORT},
      '{3'b000, 1'b1, LATCH_REPORT},
      '{3'b110, 1'b1, LATCH_REPORT},
      '{3'b000, 1'b1, LATCH_REPORT},
      '{3'b000, 1'b0, '0},
      '{3'b110, 1'b0, '0},
      '{3'b011, 1'b0, '0},
      '{3'b101, 1'b0, '0},
      '{3'b000, 1'b0, '0},
      '{3'b001, 1'b0, '0},
      '{3'b000, 1'b0, '0},
      '{3'b110, 1'b0, '0}
   };

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   snpp_req_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   snpp_rsp_type rsp_word;
   logic         csr_write_en;
   logic         csr_index;
   logic [7:0]   csr_wdata;

   // local copy of the sequencer and configuration
   snpp_phase_type seq_phase;
   logic [7:0]     seq_ticks;
   logic [5:0]     seq_bits;
   logic [31:0]    shift_bits;
   logic [31:0]    read_bytes;
   logic [31:0]    reported_bytes;
   logic [7:0]     latch_cfg;
   logic [7:0]     half_cfg;

   snpp_rsp_type pad_report_q[$];
   logic [31:0]  pad_pattern;
   int           mismatch_count;
   int           cycle_count;
   int           send_idle_pct;
   int           recv_stall_pct;
   int           hold_asks;
   int           hold_seen;
   int           hold_left;

   snes_pad_mouse_poller_unit uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_word     (req_word),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_word     (rsp_word),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one tick of the poll sequencer, returns the report for that tick
   function automatic snpp_rsp_type next_pad_report(input snpp_req_type w);
      snpp_rsp_type r;
      int           dur;
      logic [3:0]   nib;
      r = '0;
      if (seq_phase == PH_IDLE && w.start_poll) begin
         seq_phase  = PH_LATCH;
         seq_ticks  = '0;
         seq_bits   = '0;
         shift_bits = '0;
      end
      r.latch_level = (seq_phase == PH_LATCH);
      r.clock_level = (seq_phase != PH_LOW);
      r.busy_res    = (seq_phase != PH_IDLE);
      case (seq_phase)
         PH_LATCH: begin
            dur = (latch_cfg == 8'd0) ? 1 : int'(latch_cfg);
            if (int'(seq_ticks) + 1 >= dur) begin
               seq_phase = PH_HIGH;
               seq_ticks = '0;
            end else begin
               seq_ticks = seq_ticks + 8'd1;
            end
         end
         PH_HIGH: begin
            dur = (half_cfg == 8'd0) ? 1 : int'(half_cfg);
            if (int'(seq_ticks) + 1 >= dur) begin
               seq_phase = PH_LOW;
               seq_ticks = '0;
            end else begin
               seq_ticks = seq_ticks + 8'd1;
            end
         end
         PH_LOW: begin
            dur = (half_cfg == 8'd0) ? 1 : int'(half_cfg);
            // falling edge: inverted data, msb first within each byte
            if (seq_ticks == 8'd0 && !w.data_line)
               shift_bits[{seq_bits[4:3], ~seq_bits[2:0]}] = 1'b1;
            if (int'(seq_ticks) + 1 >= dur) begin
               seq_ticks = '0;
               seq_bits  = seq_bits + 6'd1;
               if (seq_bits >= POLL_BITS) begin
                  read_bytes     = shift_bits;
                  seq_phase      = PH_IDLE;
                  seq_bits       = '0;
                  r.report_valid = 1'b1;
               end else begin
                  seq_phase = PH_HIGH;
               end
            end else begin
               seq_ticks = seq_ticks + 8'd1;
            end
         end
         default: begin
            seq_phase = PH_IDLE;
            seq_ticks = '0;
         end
      endcase
      // classify from byte 1 low nibble
      nib = read_bytes[11:8];
      if (nib == NIB_NES) begin
         r.pad_kind = KIND_NES;
         r.buttons  = {8'h00, read_bytes[7:0]};
      end else begin
         r.pad_kind = (nib == NIB_MOUSE) ? KIND_MOUSE : KIND_SNES;
         r.buttons  = read_bytes[15:0];
      end
      r.raw_bytes = read_bytes;
      r.changed   = (read_bytes != reported_bytes);
      if (w.report_taken)
         reported_bytes = read_bytes;
      return r;
   endfunction

   // offer one tick word from a falling edge, return at the falling edge after
   task automatic drive_tick(input snpp_req_type w, input logic typed,
                             input snpp_rsp_type typed_report);
      snpp_rsp_type predicted;
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predicted = next_pad_report(w);
      pad_report_q.push_back(typed ? typed_report : predicted);
      @(negedge clock);
   endtask

   // random tick, mostly well formed poll data following a chosen pattern
   task automatic offer_tick(input bit allow_start);
      snpp_req_type w;
      logic [4:0]   pos;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      if (seq_phase == PH_IDLE)
         w.start_poll = allow_start && ($urandom_range(99) < 30);
      else
         w.start_poll = 1'($urandom_range(1));
      if (w.start_poll && seq_phase == PH_IDLE) begin
         pad_pattern = $urandom;
         case ($urandom_range(2))
            0: pad_pattern[11:8] = NIB_NES;
            1: pad_pattern[11:8] = NIB_MOUSE;
            default: ;
         endcase
      end
      pos = {seq_bits[4:3], ~seq_bits[2:0]};
      if ($urandom_range(9) == 0)
         w.data_line = 1'($urandom_range(1));
      else
         w.data_line = ~pad_pattern[pos];
      w.report_taken = ($urandom_range(3) == 0);
      drive_tick(w, 1'b0, '0);
   endtask

   // drop valid and wait for every predicted report
   task automatic wait_drained;
      req_valid <= 1'b0;
      while (pad_report_q.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   // run the sequencer back to idle so config may change
   task automatic finish_phase;
      while (seq_phase != PH_IDLE)
         offer_tick(1'b0);
      wait_drained();
   endtask

   task automatic run_phase(input logic [7:0] latch_val, input logic [7:0] half_val,
                            input int idle_pct, input int stall_pct, input int n_ticks,
                            input bit long_hold, input bit sender_pause);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_LATCH_TICKS;
      csr_wdata    <= latch_val;
      @(negedge clock);
      csr_index    <= CSR_HALF_PERIOD_TICKS;
      csr_wdata    <= half_val;
      @(negedge clock);
      csr_write_en <= 1'b0;
      latch_cfg      = latch_val;
      half_cfg       = half_val;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < n_ticks; i++) begin
         if (i == n_ticks / 2) begin
            if (long_hold)
               hold_asks++;
            if (sender_pause)
               wait_drained();
         end
         offer_tick(1'b1);
      end
      finish_phase();
   endtask

   // receiver back-pressure, with an occasional long hold-off
   always @(negedge clock) begin
      if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         hold_left = HOLD_TICKS;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // compare each accepted response word with the oldest prediction
   always @(posedge clock) begin : rsp_check
      snpp_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pad_report_q.size() == 0) begin
            $display("%0t: unexpected response word, expected none actual %0h",
                     $time, rsp_word);
            mismatch_count++;
         end else begin
            want = pad_report_q.pop_front();
            check_field("latch_level", want.latch_level, rsp_word.latch_level);
            check_field("clock_level", want.clock_level, rsp_word.clock_level);
            check_field("busy_res", want.busy_res, rsp_word.busy_res);
            check_field("report_valid", want.report_valid, rsp_word.report_valid);
            check_field("pad_kind", want.pad_kind, rsp_word.pad_kind);
            check_field("buttons", want.buttons, rsp_word.buttons);
            check_field("raw_bytes", want.raw_bytes, rsp_word.raw_bytes);
            check_field("changed", want.changed, rsp_word.changed);
         end
      end
   end

   // run time guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= TICK_LIMIT) begin
         $display("[snes_pad_mouse_poller_unit] ERROR");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_word       = '0;
      rsp_stall      = 1'b0;
      csr_write_en   = 1'b0;
      csr_index      = CSR_LATCH_TICKS;
      csr_wdata      = '0;
      mismatch_count = 0;
      cycle_count    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_asks      = 0;
      hold_seen      = 0;
      hold_left      = 0;
      seq_phase      = PH_IDLE;
      seq_ticks      = '0;
      seq_bits       = '0;
      shift_bits     = '0;
      read_bytes     = '0;
      reported_bytes = '0;
      latch_cfg      = LATCH_TICKS_RST;
      half_cfg       = HALF_PERIOD_TICKS_RST;
      pad_pattern    = $urandom;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table under the reset settings
      for (int i = 0; i < DIR_ROWS; i++)
         drive_tick(DIR_TABLE[i].word, DIR_TABLE[i].typed, DIR_TABLE[i].report);
      finish_phase();

      // random polls: shortest timing, zero durations, sender pause, long latch, slower clock, long hold
      run_phase(8'd1, 8'd1, 0, 0, 50, 1'b0, 1'b0);
      run_phase(8'd0, 8'd0, 49, 0, 50, 1'b0, 1'b0);
      run_phase(8'd3, 8'd2, 0, 49, 60, 1'b0, 1'b1);
      run_phase(8'd255, 8'd1, 38, 38, 40, 1'b0, 1'b0);
      run_phase(8'd2, 8'd3, 38, 38, 20, 1'b0, 1'b0);
      run_phase(8'd1, 8'd1, 0, 0, 80, 1'b1, 1'b0);

      while (pad_report_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("[snes_pad_mouse_poller_unit] OK");
      else
         $display("[snes_pad_mouse_poller_unit] ERROR");
      $finish;
   end

endmodule
